@@ rtl/phase_field_cell_update_with_pinning_core_macros.svh @@
// Assertion macros for the phase field cell update core.
// Included by the top level; no other dependencies.
`ifndef PHASE_FIELD_CELL_UPDATE_WITH_PINNING_CORE_MACROS_SVH
`define PHASE_FIELD_CELL_UPDATE_WITH_PINNING_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PFCU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("pfcu: same-cycle check failed");
`define PFCU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("pfcu: next-cycle check failed");
`else
`define PFCU_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PFCU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/pfcu_pkg.sv @@
// Shared types and constants for the phase field cell update core.
// No dependencies.
package pfcu_pkg;
	localparam int DEF_FRAC_BITS = 14;
	localparam int COEF_BITS = 12;
	localparam int REG_W = 16;
	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_MOBILITY,
		REG_LINEAR,
		REG_CUBIC,
		REG_COUPLING,
		REG_GRADIENT,
		REG_TIME_STEP,
		REG_LAPLACE,
		REG_FRICTION
	} reg_idx_t;

	typedef struct packed {
		logic [REG_W-1:0] mobility;
		logic [REG_W-1:0] linear_coeff;
		logic [REG_W-1:0] cubic_coeff;
		logic [REG_W-1:0] coupling_coeff;
		logic [REG_W-1:0] gradient_coeff;
		logic [REG_W-1:0] time_step;
		logic [REG_W-1:0] laplace_scale;
		logic [REG_W-1:0] friction_force;
	} cfg_t;

	localparam logic [REG_W-1:0] RST_MOBILITY = 16'd4096;
	localparam logic [REG_W-1:0] RST_LINEAR   = 16'd8192;
	localparam logic [REG_W-1:0] RST_CUBIC    = 16'd8192;
	localparam logic [REG_W-1:0] RST_COUPLING = 16'd12288;
	localparam logic [REG_W-1:0] RST_GRADIENT = 16'd16384;
	localparam logic [REG_W-1:0] RST_TIME     = 16'd205;
	localparam logic [REG_W-1:0] RST_LAPLACE  = 16'd2731;
	localparam logic [REG_W-1:0] RST_FRICTION = 16'd0;
endpackage

@@ rtl/pfcu_sat.sv @@
// Signed saturation from a wide value to a narrower signed range.
// Uses no package.
module pfcu_sat #(
	parameter int IW = 24,
	parameter int OW = 22
) (
	input  logic signed [IW-1:0] din,
	output logic signed [OW-1:0] dout
);
	logic [IW-OW:0] hi;
	logic ovf;

	always_comb begin
		hi = din[IW-1:OW-1];
		ovf = !(&hi) && (|hi);
		if (ovf) begin
			dout = din[IW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
		end else begin
			dout = din[OW-1:0];
		end
	end
endmodule

@@ rtl/pfcu_cfg_regs.sv @@
// Configuration register file of the phase field cell update core.
// Depends on pfcu_pkg for the register indexes and reset values.
module pfcu_cfg_regs import pfcu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data,
	output cfg_t             cfg
);
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mobility       <= RST_MOBILITY;
			cfg_q.linear_coeff   <= RST_LINEAR;
			cfg_q.cubic_coeff    <= RST_CUBIC;
			cfg_q.coupling_coeff <= RST_COUPLING;
			cfg_q.gradient_coeff <= RST_GRADIENT;
			cfg_q.time_step      <= RST_TIME;
			cfg_q.laplace_scale  <= RST_LAPLACE;
			cfg_q.friction_force <= RST_FRICTION;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MOBILITY:  cfg_q.mobility       <= cfg_data;
				REG_LINEAR:    cfg_q.linear_coeff   <= cfg_data;
				REG_CUBIC:     cfg_q.cubic_coeff    <= cfg_data;
				REG_COUPLING:  cfg_q.coupling_coeff <= cfg_data;
				REG_GRADIENT:  cfg_q.gradient_coeff <= cfg_data;
				REG_TIME_STEP: cfg_q.time_step      <= cfg_data;
				REG_LAPLACE:   cfg_q.laplace_scale  <= cfg_data;
				REG_FRICTION:  cfg_q.friction_force <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

@@ rtl/pfcu_front.sv @@
// Stages 1 to 3: stencil sum, Laplacian, powers, bulk products and pinning term.
// Depends on pfcu_pkg and pfcu_sat.
module pfcu_front import pfcu_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	localparam int VW = FRAC_BITS + 1,
	localparam int SW = FRAC_BITS + 8,
	localparam int ACW = FRAC_BITS + 5,
	localparam int BCW = FRAC_BITS + 7,
	localparam int GCW = FRAC_BITS + 8,
	localparam int KW = SW + 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  cfg_t                 cfg,
	input  logic [VW-1:0]        centre,
	input  logic [VW-1:0]        east,
	input  logic [VW-1:0]        west,
	input  logic [VW-1:0]        north,
	input  logic [VW-1:0]        south,
	input  logic [VW-1:0]        north_east,
	input  logic [VW-1:0]        south_west,
	input  logic [VW-1:0]        north_west,
	input  logic [VW-1:0]        south_east,
	input  logic [VW-1:0]        other_phase,
	output logic                 valid_s3,
	output logic [VW-1:0]        c_s3,
	output logic [ACW-1:0]       ac_s3,
	output logic [BCW-1:0]       bc_s3,
	output logic [GCW-1:0]       gc_s3,
	output logic signed [KW-1:0] kd_s3,
	output logic signed [SW-1:0] pin_s3
);
	localparam int LW = FRAC_BITS + 7;
	localparam int CCW = FRAC_BITS + 2;
	localparam int C3W = FRAC_BITS + 3;
	localparam int QW = FRAC_BITS + 4;
	localparam logic [VW:0] ONE_V = (VW + 1)'(1) << FRAC_BITS;

	// stage 1
	logic [VW+1:0] sum_e, sum_d;
	logic [LW-1:0] lap_c;
	logic [2*VW-1:0] p_cc, p_oo;
	logic signed [VW:0] omc;
	logic signed [2*VW+1:0] p_q;
	logic valid_s1;
	logic [VW-1:0] c_s1;
	logic signed [LW-1:0] lap_s1;
	logic [CCW-1:0] cc_s1, oo_s1;
	logic signed [QW-1:0] q_s1;

	always_comb begin
		sum_e = (VW + 2)'(east) + (VW + 2)'(west) + (VW + 2)'(north) + (VW + 2)'(south);
		sum_d = (VW + 2)'(north_east) + (VW + 2)'(south_west)
		      + (VW + 2)'(north_west) + (VW + 2)'(south_east);
		// 4*edges + diagonals - 20*centre, exact in two's complement
		lap_c = (LW'(sum_e) << 2) + LW'(sum_d) - (LW'(centre) << 4) - (LW'(centre) << 2);
		p_cc = (2 * VW)'(centre) * (2 * VW)'(centre);
		p_oo = (2 * VW)'(other_phase) * (2 * VW)'(other_phase);
		omc = $signed(ONE_V - (VW + 1)'(centre));
		p_q = $signed({1'b0, centre}) * omc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= centre;
			lap_s1 <= $signed(lap_c);
			cc_s1 <= p_cc[FRAC_BITS+CCW-1:FRAC_BITS];
			oo_s1 <= p_oo[FRAC_BITS+CCW-1:FRAC_BITS];
			q_s1 <= p_q[FRAC_BITS+QW-1:FRAC_BITS];
		end
	end

	// stage 2
	logic signed [LW+16:0] p_del;
	logic signed [SW-1:0] del_sat;
	logic [VW+CCW-1:0] p_c3, p_co2;
	logic signed [QW+1:0] q3;
	logic signed [QW+18:0] p_pin;
	logic signed [SW-1:0] pin_sat;
	logic [REG_W+VW-1:0] p_ac;
	logic valid_s2;
	logic [VW-1:0] c_s2;
	logic signed [SW-1:0] del_s2, pin_s2;
	logic [C3W-1:0] c3_s2, co2_s2;
	logic [ACW-1:0] ac_s2;

	always_comb begin
		p_del = $signed({1'b0, cfg.laplace_scale}) * lap_s1;
		p_c3 = (VW + CCW)'(c_s1) * (VW + CCW)'(cc_s1);
		p_co2 = (VW + CCW)'(c_s1) * (VW + CCW)'(oo_s1);
		q3 = ((QW + 2)'(q_s1) <<< 1) + (QW + 2)'(q_s1);
		p_pin = q3 * $signed({1'b0, cfg.friction_force});
		p_ac = (REG_W + VW)'(cfg.linear_coeff) * (REG_W + VW)'(c_s1);
	end

	pfcu_sat #(.IW(LW + 3), .OW(SW)) u_sat_del (
		.din  (p_del[LW+16:COEF_BITS+2]),
		.dout (del_sat)
	);

	pfcu_sat #(.IW(QW + 7), .OW(SW)) u_sat_pin (
		.din  (p_pin[QW+18:COEF_BITS]),
		.dout (pin_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2 <= c_s1;
			del_s2 <= del_sat;
			pin_s2 <= pin_sat;
			c3_s2 <= p_c3[FRAC_BITS+C3W-1:FRAC_BITS];
			co2_s2 <= p_co2[FRAC_BITS+C3W-1:FRAC_BITS];
			ac_s2 <= p_ac[REG_W+VW-1:COEF_BITS];
		end
	end

	// stage 3
	logic signed [SW+16:0] p_kd;
	logic [REG_W+C3W-1:0] p_bc, p_gc;

	always_comb begin
		p_kd = $signed({1'b0, cfg.gradient_coeff}) * del_s2;
		p_bc = (REG_W + C3W)'(cfg.cubic_coeff) * (REG_W + C3W)'(c3_s2);
		p_gc = (REG_W + C3W)'(cfg.coupling_coeff) * (REG_W + C3W)'(co2_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3 <= c_s2;
			ac_s3 <= ac_s2;
			pin_s3 <= pin_s2;
			kd_s3 <= p_kd[SW+16:COEF_BITS];
			bc_s3 <= p_bc[REG_W+C3W-1:COEF_BITS];
			// doubled coupling: drop one bit less
			gc_s3 <= p_gc[REG_W+C3W-1:COEF_BITS-1];
		end
	end
endmodule

@@ rtl/pfcu_back.sv @@
// Stages 4 to 7: driving force, pinning decision, mobility and time step, clamp.
// Depends on pfcu_pkg and pfcu_sat.
module pfcu_back import pfcu_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	localparam int VW = FRAC_BITS + 1,
	localparam int SW = FRAC_BITS + 8,
	localparam int ACW = FRAC_BITS + 5,
	localparam int BCW = FRAC_BITS + 7,
	localparam int GCW = FRAC_BITS + 8,
	localparam int KW = SW + 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  cfg_t                 cfg,
	input  logic                 valid_s3,
	input  logic [VW-1:0]        c_s3,
	input  logic [ACW-1:0]       ac_s3,
	input  logic [BCW-1:0]       bc_s3,
	input  logic [GCW-1:0]       gc_s3,
	input  logic signed [KW-1:0] kd_s3,
	input  logic signed [SW-1:0] pin_s3,
	output logic                 valid_s7,
	output logic [VW-1:0]        new_value_s7,
	output logic                 pinned_s7
);
	localparam int DW = SW + 6;
	localparam logic signed [SW+5:0] ONE_N = {{(SW + 5 - FRAC_BITS){1'b0}}, 1'b1,
		{FRAC_BITS{1'b0}}};

	// stage 4: driving force and signed pinning term
	logic [DW-1:0] dsum;
	logic signed [SW-1:0] d_sat;
	logic signed [SW:0] pinx, pinv;
	logic valid_s4;
	logic [VW-1:0] c_s4;
	logic signed [SW-1:0] d_s4;
	logic signed [SW:0] pin_s4;

	always_comb begin
		dsum = DW'(bc_s3) + DW'(gc_s3) - DW'(ac_s3) - DW'(kd_s3);
		pinx = (SW + 1)'(pin_s3);
		if (dsum[DW-1]) begin
			pinv = -pinx;
		end else if (dsum == '0) begin
			pinv = '0;
		end else begin
			pinv = pinx;
		end
	end

	pfcu_sat #(.IW(DW), .OW(SW)) u_sat_d (
		.din  ($signed(dsum)),
		.dout (d_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s4 <= c_s3;
			d_s4 <= d_sat;
			pin_s4 <= pinv;
		end
	end

	// stage 5: pinning compare and net force
	logic signed [SW:0] dx;
	logic [SW:0] abs_d, abs_pin;
	logic signed [SW+1:0] e_raw;
	logic signed [SW-1:0] e_sat;
	logic valid_s5, pinned_s5;
	logic [VW-1:0] c_s5;
	logic signed [SW-1:0] e_s5;

	always_comb begin
		dx = (SW + 1)'(d_s4);
		abs_d = dx[SW] ? $unsigned(-dx) : $unsigned(dx);
		abs_pin = pin_s4[SW] ? $unsigned(-pin_s4) : $unsigned(pin_s4);
		e_raw = (SW + 2)'(d_s4) - (SW + 2)'(pin_s4);
	end

	pfcu_sat #(.IW(SW + 2), .OW(SW)) u_sat_e (
		.din  (e_raw),
		.dout (e_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s5 <= c_s4;
			pinned_s5 <= abs_d < abs_pin;
			e_s5 <= e_sat;
		end
	end

	// stage 6: apply mobility
	logic signed [SW+16:0] p_r;
	logic signed [SW-1:0] r_sat;
	logic valid_s6, pinned_s6;
	logic [VW-1:0] c_s6;
	logic signed [SW-1:0] r_s6;

	assign p_r = $signed({1'b0, cfg.mobility}) * e_s5;

	pfcu_sat #(.IW(SW + 5), .OW(SW)) u_sat_r (
		.din  (p_r[SW+16:COEF_BITS]),
		.dout (r_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s6 <= c_s5;
			pinned_s6 <= pinned_s5;
			r_s6 <= r_sat;
		end
	end

	// stage 7: time step, clamp to [0,1], output register
	logic signed [SW+16:0] p_st;
	logic signed [SW+5:0] nv, cx;
	logic [VW-1:0] nv_clamp;

	always_comb begin
		p_st = $signed({1'b0, cfg.time_step}) * r_s6;
		cx = $signed((SW + 6)'(c_s6));
		// hold the old value when pinned; the step keeps its sign
		nv = pinned_s6 ? cx : cx - (SW + 6)'($signed(p_st[SW+16:COEF_BITS]));
		if (nv < 0) begin
			nv_clamp = '0;
		end else if (nv > ONE_N) begin
			nv_clamp = ONE_N[VW-1:0];
		end else begin
			nv_clamp = nv[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_value_s7 <= nv_clamp;
			pinned_s7 <= pinned_s6;
		end
	end
endmodule

@@ rtl/phase_field_cell_update_with_pinning_core.sv @@
// Top level of the phase field cell update core with pinning force.
// Depends on pfcu_pkg, pfcu_cfg_regs, pfcu_front, pfcu_back and the macro header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one cell: centre, its eight
//   neighbors and the other order parameter, all Q1.FRAC_BITS unsigned.
//   Output channel (out_valid/out_ready) returns new_value and pinned.
//   Configuration: cfg_we/cfg_index/cfg_data write one Q4.12 coefficient per
//   cycle; write only while no request is in flight.
//   Pipeline: an accepted request passes seven register stages, the first
//   loaded at acceptance; a held output stalls all of them.
//   Throughput: one request per cycle while the output is not held; the
//   seven-stage pipeline takes a new cell in every such cycle.
//   Stall: while out_valid is high and out_ready low, the whole pipeline
//   holds and in_ready is low; bubbles do not hold it.
//   Reset: arst_n clears all stage valid bits and loads the coefficient
//   defaults; the block accepts a request in the first cycle after reset.
`include "phase_field_cell_update_with_pinning_core_macros.svh"
module phase_field_cell_update_with_pinning_core import pfcu_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [FRAC_BITS:0]   centre,
	input  logic [FRAC_BITS:0]   east,
	input  logic [FRAC_BITS:0]   west,
	input  logic [FRAC_BITS:0]   north,
	input  logic [FRAC_BITS:0]   south,
	input  logic [FRAC_BITS:0]   north_east,
	input  logic [FRAC_BITS:0]   south_west,
	input  logic [FRAC_BITS:0]   north_west,
	input  logic [FRAC_BITS:0]   south_east,
	input  logic [FRAC_BITS:0]   other_phase,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [FRAC_BITS:0]   new_value,
	output logic                 pinned
);
	localparam int VW = FRAC_BITS + 1;
	localparam int SW = FRAC_BITS + 8;
	localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;

	cfg_t cfg;
	logic en;
	logic valid_s3;
	logic [VW-1:0] c_s3;
	logic [FRAC_BITS+4:0] ac_s3;
	logic [FRAC_BITS+6:0] bc_s3;
	logic [FRAC_BITS+7:0] gc_s3;
	logic signed [SW+4:0] kd_s3;
	logic signed [SW-1:0] pin_s3;

	// advance the pipeline unless a finished result is held
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	pfcu_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pfcu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (in_valid),
		.cfg         (cfg),
		.centre      (centre),
		.east        (east),
		.west        (west),
		.north       (north),
		.south       (south),
		.north_east  (north_east),
		.south_west  (south_west),
		.north_west  (north_west),
		.south_east  (south_east),
		.other_phase (other_phase),
		.valid_s3    (valid_s3),
		.c_s3        (c_s3),
		.ac_s3       (ac_s3),
		.bc_s3       (bc_s3),
		.gc_s3       (gc_s3),
		.kd_s3       (kd_s3),
		.pin_s3      (pin_s3)
	);

	pfcu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.cfg          (cfg),
		.valid_s3     (valid_s3),
		.c_s3         (c_s3),
		.ac_s3        (ac_s3),
		.bc_s3        (bc_s3),
		.gc_s3        (gc_s3),
		.kd_s3        (kd_s3),
		.pin_s3       (pin_s3),
		.valid_s7     (out_valid),
		.new_value_s7 (new_value),
		.pinned_s7    (pinned)
	);

	`PFCU_ASSERT_IMPL(a_clamped, clk, arst_n, out_valid, new_value <= ONE_V)
	`PFCU_ASSERT_IMPL(a_no_pin_without_force, clk, arst_n, out_valid && (cfg.friction_force == '0), !pinned)
	`PFCU_ASSERT_IMPL(a_stall_blocks_input, clk, arst_n, out_valid && !out_ready, !in_ready)
	`PFCU_ASSERT_NEXT(a_hold_result, clk, arst_n, out_valid && !out_ready, out_valid && $stable(new_value) && $stable(pinned))
endmodule

@@ verif/tb_phase_field_cell_update_with_pinning_core.sv @@
// Self-checking testbench for phase_field_cell_update_with_pinning_core.
// Predicts each cell update from its own copy of the coefficient registers.
// Depends on pfcu_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_phase_field_cell_update_with_pinning_core;
	import pfcu_pkg::*;

	localparam int FB = DEF_FRAC_BITS;
	localparam int VW = FB + 1;
	localparam longint ONE = 64'sd1 << FB;
	localparam int ONE_I = 1 << FB;
	localparam int MAX_I = (1 << VW) - 1;
	localparam longint SAT_HI = (64'sd1 << (FB + 8)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [FB:0] centre;
		logic [FB:0] east;
		logic [FB:0] west;
		logic [FB:0] north;
		logic [FB:0] south;
		logic [FB:0] north_east;
		logic [FB:0] south_west;
		logic [FB:0] north_west;
		logic [FB:0] south_east;
		logic [FB:0] other_phase;
	} cell_t;

	typedef struct packed {
		logic [FB:0] value;
		logic        pinned;
	} update_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	cell_t req;
	logic [FB:0] new_value;
	logic pinned;

	logic [REG_W-1:0] coeff [8];
	cell_t cells_pending [$];
	update_t updates_due [$];
	int mismatches = 0;
	int cycles = 0;
	bit in_fire = 0, out_fire = 0;
	int send_gap = 0, recv_gap = 0;
	bit send_burst = 0, recv_burst = 0;

	phase_field_cell_update_with_pinning_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.centre(req.centre), .east(req.east), .west(req.west),
		.north(req.north), .south(req.south),
		.north_east(req.north_east), .south_west(req.south_west),
		.north_west(req.north_west), .south_east(req.south_east),
		.other_phase(req.other_phase),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_value(new_value), .pinned(pinned)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic longint clip(longint x);
		if (x > SAT_HI) return SAT_HI;
		if (x < SAT_LO) return SAT_LO;
		return x;
	endfunction

	function automatic longint mag(longint x);
		return x < 0 ? -x : x;
	endfunction

	// One explicit Allen-Cahn step with friction; >>> on signed floors.
	function automatic update_t cell_update(cell_t p);
		longint c, o, lap, del2, cc, c3, oo, co2, drive, q, pin, e, r, nv;
		longint mob, alpha, beta, gam, kap, dt, scl, pz;
		update_t u;
		mob = coeff[REG_MOBILITY];
		alpha = coeff[REG_LINEAR];
		beta = coeff[REG_CUBIC];
		gam = coeff[REG_COUPLING];
		kap = coeff[REG_GRADIENT];
		dt = coeff[REG_TIME_STEP];
		scl = coeff[REG_LAPLACE];
		pz = coeff[REG_FRICTION];
		c = p.centre;
		o = p.other_phase;
		lap = 4 * (longint'(p.east) + p.west + p.north + p.south)
			+ (longint'(p.north_east) + p.south_west + p.north_west + p.south_east)
			- 20 * c;
		del2 = clip((scl * lap) >>> (COEF_BITS + 2));
		cc = (c * c) >>> FB;
		c3 = (c * cc) >>> FB;
		oo = (o * o) >>> FB;
		co2 = (c * oo) >>> FB;
		drive = -((alpha * c) >>> COEF_BITS) + ((beta * c3) >>> COEF_BITS)
			- ((kap * del2) >>> COEF_BITS) + ((2 * gam * co2) >>> COEF_BITS);
		drive = clip(drive);
		q = (c * (ONE - c)) >>> FB;
		pin = clip((3 * q * pz) >>> COEF_BITS);
		if (drive < 0)
			pin = -pin;
		else if (drive == 0)
			pin = 0;
		u.pinned = mag(drive) < mag(pin);
		if (u.pinned) begin
			nv = c;
		end else begin
			e = clip(drive - pin);
			r = clip((mob * e) >>> COEF_BITS);
			nv = c - ((dt * r) >>> COEF_BITS);
		end
		if (nv > ONE) nv = ONE;
		if (nv < 0) nv = 0;
		u.value = nv[FB:0];
		return u;
	endfunction

	function automatic cell_t flat_cell(int c, int nb, int o);
		cell_t p;
		p.centre = VW'(c);
		p.east = VW'(nb); p.west = VW'(nb); p.north = VW'(nb); p.south = VW'(nb);
		p.north_east = VW'(nb); p.south_west = VW'(nb);
		p.north_west = VW'(nb); p.south_east = VW'(nb);
		p.other_phase = VW'(o);
		return p;
	endfunction

	function automatic logic [FB:0] near_value(int c, int spread);
		int v;
		v = c + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0) v = 0;
		if (v > ONE_I) v = ONE_I;
		return VW'(v);
	endfunction

	function automatic logic [FB:0] any_value();
		return VW'($urandom_range(0, ONE_I));
	endfunction

	function automatic cell_t random_cell();
		cell_t p;
		logic [159:0] raw;
		int kind, c, s;
		kind = int'($urandom_range(0, 7));
		if (kind == 0) begin
			// whole 15-bit range, values above 1.0 included
			raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
			p = raw[$bits(cell_t)-1:0];
		end else if (kind <= 4) begin
			// smooth neighborhood: small driving force, where pinning bites
			c = int'($urandom_range(0, ONE_I));
			s = $urandom_range(0, 3) == 0 ? 2000 : 60;
			p.centre = VW'(c);
			p.east = near_value(c, s); p.west = near_value(c, s);
			p.north = near_value(c, s); p.south = near_value(c, s);
			p.north_east = near_value(c, s); p.south_west = near_value(c, s);
			p.north_west = near_value(c, s); p.south_east = near_value(c, s);
			p.other_phase = any_value();
		end else begin
			p.centre = any_value();
			p.east = any_value(); p.west = any_value();
			p.north = any_value(); p.south = any_value();
			p.north_east = any_value(); p.south_west = any_value();
			p.north_west = any_value(); p.south_east = any_value();
			p.other_phase = any_value();
		end
		return p;
	endfunction

	task automatic write_coeff(reg_idx_t idx, logic [REG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		coeff[idx] = val;
	endtask

	task automatic load_coeffs(logic [REG_W-1:0] v [8]);
		reg_idx_t idx;
		idx = idx.first();
		for (int k = 0; k < 8; k++) begin
			write_coeff(idx, v[k]);
			idx = idx.next();
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (cells_pending.size() == 0 && !in_valid && updates_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_directed();
		cells_pending.push_back(flat_cell(0, 0, 0));
		cells_pending.push_back(flat_cell(ONE_I, ONE_I, ONE_I));
		cells_pending.push_back(flat_cell(ONE_I, ONE_I, 0));
		cells_pending.push_back(flat_cell(MAX_I, MAX_I, MAX_I));
		cells_pending.push_back(flat_cell(0, ONE_I, 0));
		cells_pending.push_back(flat_cell(ONE_I, 0, 0));
		cells_pending.push_back(flat_cell(0, MAX_I, MAX_I));
		cells_pending.push_back(flat_cell(ONE_I / 2, ONE_I / 2, ONE_I));
		cells_pending.push_back(flat_cell(ONE_I / 2, ONE_I / 2, 0));
		cells_pending.push_back(flat_cell(ONE_I / 2, ONE_I / 2 + 3, ONE_I / 2));
		cells_pending.push_back(flat_cell(20000, 20000, 0));
		cells_pending.push_back(flat_cell(ONE_I / 4, ONE_I / 4, ONE_I / 4));
		cells_pending.push_back(flat_cell(3 * ONE_I / 4, 3 * ONE_I / 4, ONE_I));
		cells_pending.push_back(flat_cell(1, 0, 0));
		cells_pending.push_back(flat_cell(ONE_I - 1, ONE_I, ONE_I));
		cells_pending.push_back(flat_cell(MAX_I, 0, MAX_I));
	endtask

	task automatic queue_random(int n);
		for (int k = 0; k < n; k++)
			cells_pending.push_back(random_cell());
	endtask

	// Request driver: inputs change on the falling edge.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (cells_pending.size() > 0) begin
				req <= cells_pending.pop_front();
				in_valid <= 1'b1;
				if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
				send_gap = send_burst ? 0 : int'($urandom_range(0, 4));
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result backpressure: drop ready for a drawn number of cycles per result.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire) begin
				if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
				recv_gap = recv_burst ? 0 : int'($urandom_range(0, 4));
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: predict on request acceptance, check on result acceptance.
	always @(posedge clk) begin
		update_t want;
		in_fire = in_valid && in_ready;
		out_fire = out_valid && out_ready;
		if (arst_n) begin
			if (in_fire)
				updates_due.push_back(cell_update(req));
			if (out_fire) begin
				if (updates_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: new_value=%0d pinned=%0b",
							new_value, pinned);
				end else begin
					want = updates_due.pop_front();
					if (new_value !== want.value || pinned !== want.pinned) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: new_value exp %0d got %0d, pinned exp %0b got %0b",
								want.value, new_value, want.pinned, pinned);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [REG_W-1:0] set [8];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		req = '0;
		coeff[REG_MOBILITY] = RST_MOBILITY;
		coeff[REG_LINEAR] = RST_LINEAR;
		coeff[REG_CUBIC] = RST_CUBIC;
		coeff[REG_COUPLING] = RST_COUPLING;
		coeff[REG_GRADIENT] = RST_GRADIENT;
		coeff[REG_TIME_STEP] = RST_TIME;
		coeff[REG_LAPLACE] = RST_LAPLACE;
		coeff[REG_FRICTION] = RST_FRICTION;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// reset coefficients, no friction
		queue_directed();
		queue_random(150);
		drain();

		// defaults with a strong friction force
		set = '{RST_MOBILITY, RST_LINEAR, RST_CUBIC, RST_COUPLING,
			RST_GRADIENT, RST_TIME, RST_LAPLACE, 16'd2048};
		load_coeffs(set);
		queue_directed();
		queue_random(150);
		drain();

		// every coefficient at its maximum: saturation everywhere
		set = '{default: 16'hFFFF};
		load_coeffs(set);
		queue_directed();
		queue_random(50);
		drain();

		// every coefficient zero: output equals clamped centre
		set = '{default: 16'h0000};
		load_coeffs(set);
		queue_random(40);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			for (int k = 0; k < 8; k++)
				set[k] = $urandom_range(0, 3) == 0 ? REG_W'($urandom)
					: REG_W'($urandom_range(0, 16384));
			set[REG_TIME_STEP] = REG_W'($urandom_range(0, 3000));
			set[REG_FRICTION] = $urandom_range(0, 1) ? REG_W'($urandom_range(0, 600))
				: REG_W'($urandom);
			load_coeffs(set);
			queue_random(55);
			drain();
		end

		if (mismatches == 0 && updates_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl
rtl/pfcu_pkg.sv
rtl/pfcu_sat.sv
rtl/pfcu_cfg_regs.sv
rtl/pfcu_front.sv
rtl/pfcu_back.sv
rtl/phase_field_cell_update_with_pinning_core.sv
verif/tb_phase_field_cell_update_with_pinning_core.sv
